// ===== rtl/core/rfhls_pkg.sv =====
// ============================================================================
// rfhls_pkg: shared types and constants of the hopping link scheduler
// Beat structs, configuration register set, register indexes and the hop
// channel table.
// ============================================================================
`default_nettype none

package rfhls_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TX_SLOT        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RX_SLOT        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOP_SLOT       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LENGTH   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELINK_CHANNEL = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_LIMIT     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_HIGH      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM_LOW       = 4'd7;

  // Command codes of an input beat.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  localparam logic [7:0] TOGGLE_MASK  = 8'h1e;
  localparam logic [7:0] LEVEL_MASK   = 8'h60;
  localparam logic [9:0] RESYNC_VALUE = 10'd3;

  typedef struct packed {
    logic [9:0]  tx_slot;
    logic [9:0]  rx_slot;
    logic [9:0]  hop_slot;
    logic [9:0]  cycle_length;
    logic [6:0]  relink_channel;
    logic [7:0]  loss_limit;
    logic [15:0] zoom_high;
    logic [15:0] zoom_low;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic        rx_ready;
    logic [7:0]  fn_byte;
    logic [15:0] zoom_word;
  } in_t;

  typedef struct packed {
    logic       channel_write;
    logic [6:0] channel;
    logic       send_reply;
    logic       clear_radio;
    logic       link_up;
    logic [4:0] function_events;
    logic [6:0] function_levels;
    logic       ev_increase;
    logic       ev_decrease;
  } out_t;

  // Hop channel table; entries past the tenth read as channel 0.
  function automatic logic [6:0] hop_channel(input logic [3:0] idx);
    logic [6:0] ch;
    case (idx)
      4'd0:    ch = 7'd4;
      4'd1:    ch = 7'd12;
      4'd2:    ch = 7'd18;
      4'd3:    ch = 7'd27;
      4'd4:    ch = 7'd36;
      4'd5:    ch = 7'd41;
      4'd6:    ch = 7'd47;
      4'd7:    ch = 7'd54;
      4'd8:    ch = 7'd62;
      4'd9:    ch = 7'd72;
      default: ch = 7'd0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rf_hopping_link_scheduler_unit.sv =====
// ============================================================================
// rf_hopping_link_scheduler_unit: frequency-hopping link scheduler, top level
// Input register, single-pass step logic and result register.
// ============================================================================
// Path: an accepted input beat is held in the input register, and its result
// is loaded into the result register once that register is free.
// Throughput: one beat per cycle while out_ready stays high; the step logic
// between the input register and the result register updates all link state
// in one pass, so the next beat sees the updated state.
// Reset (synchronous, active low) restores the configuration defaults, puts
// the link in the hopping step, disconnected, and empties both registers.
`default_nettype none

module rf_hopping_link_scheduler_unit #(
  parameter int unsigned HOP_CHANNELS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel.
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  rfhls_pkg::in_t                         in_data,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rfhls_pkg::out_t                        out_data,
  // Configuration write port.
  input  wire logic                              cfg_we,
  input  wire logic [rfhls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rfhls_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rfhls_pkg::*;

  cfg_t cfg;
  in_t  item_r;
  logic item_vld_r;
  out_t res;
  out_t out_r;
  logic out_vld_r;

  logic out_free;
  logic fire;
  logic in_take;

  rfhls_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The beat held in the input register moves into the result register
  // whenever that register is empty or is being drained this cycle. Link
  // state is committed at the same edge, so back-to-back beats each see the
  // state left by the one before.
  assign out_free = !out_vld_r || out_ready;
  assign fire     = item_vld_r && out_free;
  assign in_ready = !item_vld_r || fire;
  assign in_take  = in_valid && in_ready;

  rfhls_step_core #(
    .HOP_CHANNELS (HOP_CHANNELS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .item  (item_r),
    .res   (res)
  );

  // Input register: control bit is reset, payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/rfhls_cfg_regs.sv =====
// ============================================================================
// rfhls_cfg_regs: configuration register file
// Plain write port; writes to indexes beyond the register list are dropped.
// ============================================================================
`default_nettype none

module rfhls_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rfhls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rfhls_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rfhls_pkg::cfg_t                        cfg
);
  import rfhls_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tx_slot        <= '0;
      cfg_r.rx_slot        <= '0;
      cfg_r.hop_slot       <= '0;
      cfg_r.cycle_length   <= 10'd20;
      cfg_r.relink_channel <= '0;
      cfg_r.loss_limit     <= 8'd6;
      cfg_r.zoom_high      <= 16'hd50;
      cfg_r.zoom_low       <= 16'hb20;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TX_SLOT:        cfg_r.tx_slot        <= cfg_wdata[9:0];
        REG_RX_SLOT:        cfg_r.rx_slot        <= cfg_wdata[9:0];
        REG_HOP_SLOT:       cfg_r.hop_slot       <= cfg_wdata[9:0];
        REG_CYCLE_LENGTH:   cfg_r.cycle_length   <= cfg_wdata[9:0];
        REG_RELINK_CHANNEL: cfg_r.relink_channel <= cfg_wdata[6:0];
        REG_LOSS_LIMIT:     cfg_r.loss_limit     <= cfg_wdata[7:0];
        REG_ZOOM_HIGH:      cfg_r.zoom_high      <= cfg_wdata;
        REG_ZOOM_LOW:       cfg_r.zoom_low       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/rfhls_step_core.sv =====
// ============================================================================
// rfhls_step_core: scheduler state and per-beat update logic
// Holds the link state and computes one result per beat in a single pass.
// ============================================================================
`default_nettype none

module rfhls_step_core #(
  parameter int unsigned HOP_CHANNELS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  rfhls_pkg::cfg_t  cfg,
  input  wire logic        fire,
  input  rfhls_pkg::in_t   item,
  output rfhls_pkg::out_t  res
);
  import rfhls_pkg::*;

  localparam int unsigned IDX_W = (HOP_CHANNELS > 1) ? $clog2(HOP_CHANNELS) : 1;

  typedef enum logic [1:0] {
    STEP_IDLE = 2'd0,
    STEP_TX   = 2'd1,
    STEP_RX   = 2'd2,
    STEP_HOP  = 2'd3
  } step_t;

  logic [9:0]       slot_r,  slot_nxt;
  step_t            step_r,  step_nxt;
  logic [IDX_W-1:0] hop_r,   hop_nxt;
  logic [7:0]       loss_r,  loss_nxt;
  logic             conn_r,  conn_nxt;
  logic [7:0]       pend_r,  pend_nxt;
  logic [7:0]       prev_r,  prev_nxt;
  logic [1:0]       ev_r,    ev_nxt;

  logic [9:0]       tick_cnt;
  logic [IDX_W:0]   hop_inc;

  assign tick_cnt = slot_r + 10'd1;
  assign hop_inc  = {1'b0, hop_r} + {{IDX_W{1'b0}}, 1'b1};

  always_comb begin
    slot_nxt = slot_r;
    step_nxt = step_r;
    hop_nxt  = hop_r;
    loss_nxt = loss_r;
    conn_nxt = conn_r;
    pend_nxt = pend_r;
    prev_nxt = prev_r;
    ev_nxt   = ev_r;
    res      = '0;

    if (item.command == CMD_TICK) begin
      // When slots coincide, hop wins over receive over transmit.
      if (tick_cnt == cfg.hop_slot) begin
        step_nxt = STEP_HOP;
      end else if (tick_cnt == cfg.rx_slot) begin
        step_nxt = STEP_RX;
      end else if (tick_cnt == cfg.tx_slot) begin
        step_nxt = STEP_TX;
      end
      slot_nxt = (tick_cnt >= cfg.cycle_length) ? 10'd0 : tick_cnt;
    end else if (step_r == STEP_HOP) begin
      res.channel_write = 1'b1;
      if (loss_r < cfg.loss_limit) begin
        loss_nxt = loss_r + 8'd1;
        conn_nxt = 1'b1;
        hop_nxt  = (hop_inc >= (IDX_W+1)'(HOP_CHANNELS)) ? '0 : hop_inc[IDX_W-1:0];
        res.channel = hop_channel(4'(hop_nxt));
      end else begin
        conn_nxt    = 1'b0;
        hop_nxt     = '0;
        res.channel = cfg.relink_channel;
      end
      step_nxt = STEP_RX;
    end else if (step_r == STEP_RX || !conn_r) begin
      if (item.rx_ready) begin
        loss_nxt = '0;
        if (conn_r) begin
          res.function_events = pend_r[4:0] & TOGGLE_MASK[4:0];
          ev_nxt   = {item.zoom_word < cfg.zoom_low, item.zoom_word > cfg.zoom_high};
          pend_nxt = ((prev_r ^ item.fn_byte) & TOGGLE_MASK)
                   | (item.fn_byte & LEVEL_MASK);
        end
        prev_nxt       = item.fn_byte;
        conn_nxt       = 1'b1;
        step_nxt       = STEP_IDLE;
        slot_nxt       = RESYNC_VALUE;
        res.send_reply = 1'b1;
      end
    end else if (step_r == STEP_TX) begin
      res.clear_radio = 1'b1;
      step_nxt        = STEP_IDLE;
    end

    res.link_up         = conn_nxt;
    res.function_levels = pend_nxt[6:0] & LEVEL_MASK[6:0];
    res.ev_increase     = ev_nxt[0];
    res.ev_decrease     = ev_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      step_r <= STEP_HOP;
      hop_r  <= '0;
      loss_r <= '0;
      conn_r <= 1'b0;
      pend_r <= '0;
      prev_r <= '0;
      ev_r   <= '0;
    end else if (fire) begin
      slot_r <= slot_nxt;
      step_r <= step_nxt;
      hop_r  <= hop_nxt;
      loss_r <= loss_nxt;
      conn_r <= conn_nxt;
      pend_r <= pend_nxt;
      prev_r <= prev_nxt;
      ev_r   <= ev_nxt;
    end
  end

endmodule

`default_nettype wire
